>>> rtl/assert_macros.svh
// Assertion macros used by the checker file of the biquad filter.
// Each macro wraps one clocked concurrent assertion with a reset guard.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

>>> rtl/biq_pkg.sv
// Shared types and constants of the biquad filter.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package biq_pkg;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_B0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_B1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_B2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_A1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_A2 = 3'd4;

  // Request command codes.
  localparam logic CMD_FILTER = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_Y,
    ST_A1,
    ST_B2,
    ST_A2,
    ST_FIN
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_CLEAR,
    OP_Y,
    OP_A1,
    OP_B2,
    OP_A2,
    OP_FIN
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

>>> rtl/biq_ctrl.sv
// Sequencer of the biquad filter: steps the shared multiplier through five products.
// Depends on biq_pkg.
`default_nettype none

module biq_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire logic            cmd,
  output logic                 in_stall,
  output biq_pkg::dp_cmd_t     dp_cmd,
  input  wire biq_pkg::dp_stat_t dp_stat
);

  biq_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= biq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      biq_pkg::ST_IDLE: begin
        if (in_valid && (cmd == biq_pkg::CMD_FILTER)) state_next = biq_pkg::ST_Y;
      end
      biq_pkg::ST_Y:  state_next = biq_pkg::ST_A1;
      biq_pkg::ST_A1: state_next = biq_pkg::ST_B2;
      biq_pkg::ST_B2: state_next = biq_pkg::ST_A2;
      biq_pkg::ST_A2: state_next = biq_pkg::ST_FIN;
      biq_pkg::ST_FIN: begin
        if (dp_stat.out_free) state_next = biq_pkg::ST_IDLE;
      end
      default: state_next = biq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    dp_cmd.op = biq_pkg::OP_NONE;
    case (state)
      biq_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          dp_cmd.op = (cmd == biq_pkg::CMD_CLEAR) ? biq_pkg::OP_CLEAR : biq_pkg::OP_LOAD;
        end
      end
      biq_pkg::ST_Y:  dp_cmd.op = biq_pkg::OP_Y;
      biq_pkg::ST_A1: dp_cmd.op = biq_pkg::OP_A1;
      biq_pkg::ST_B2: dp_cmd.op = biq_pkg::OP_B2;
      biq_pkg::ST_A2: dp_cmd.op = biq_pkg::OP_A2;
      biq_pkg::ST_FIN: begin
        if (dp_stat.out_free) dp_cmd.op = biq_pkg::OP_FIN;
      end
      default: dp_cmd.op = biq_pkg::OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/biq_datapath.sv
// Datapath of the biquad filter: coefficients, shared multiplier, accumulator,
// delay state and output register. Depends on biq_pkg.
`default_nettype none

module biq_datapath #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int COEF_WIDTH   = 18,
  parameter int ACC_WIDTH    = 40
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [biq_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [COEF_WIDTH-1:0]               cfg_data,
  input  wire logic signed [SAMPLE_WIDTH-1:0]      sample_in,
  input  wire biq_pkg::dp_cmd_t                    dp_cmd,
  output biq_pkg::dp_stat_t                        dp_stat,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]           sample_out,
  output logic                                     clipped
);

  localparam int PROD_W = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int SUM_W  = ((PROD_W > ACC_WIDTH) ? PROD_W : ACC_WIDTH) + 2;
  localparam int FRAC   = COEF_WIDTH - 4;
  localparam int SHR_W  = SUM_W - FRAC;

  localparam logic signed [COEF_WIDTH-1:0] COEF_ONE =
    {3'b000, 1'b1, {FRAC{1'b0}}};
  localparam logic signed [SUM_W-1:0] ROUND =
    {{(SUM_W-FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};
  localparam logic signed [SUM_W-1:0] ACC_MAX =
    {{(SUM_W-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] ACC_MIN =
    {{(SUM_W-ACC_WIDTH+1){1'b1}}, {(ACC_WIDTH-1){1'b0}}};
  localparam logic signed [SHR_W-1:0] Y_MAX =
    {{(SHR_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SHR_W-1:0] Y_MIN =
    {{(SHR_W-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};

  logic signed [COEF_WIDTH-1:0]   coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
  logic signed [SAMPLE_WIDTH-1:0] x_reg, y_reg;
  logic                           clip_reg;
  logic signed [PROD_W-1:0]       prod;
  logic signed [SUM_W-1:0]        acc;
  logic signed [ACC_WIDTH-1:0]    delay_first, delay_second;

  logic signed [COEF_WIDTH-1:0]   mul_coef;
  logic signed [SAMPLE_WIDTH-1:0] mul_data;
  logic                           mul_en;
  logic signed [SUM_W-1:0]        prod_ext, sum_y, n1_sum, n2_sum;
  logic signed [SHR_W-1:0]        y_shr;
  logic signed [SAMPLE_WIDTH-1:0] y_sat;
  logic                           y_hit;
  logic signed [ACC_WIDTH-1:0]    n1_sat, n2_sat;

  function automatic logic signed [ACC_WIDTH-1:0] clamp_acc(
    input logic signed [SUM_W-1:0] v
  );
    logic signed [SUM_W-1:0] r;
    begin
      r = v;
      if (v > ACC_MAX) r = ACC_MAX;
      else if (v < ACC_MIN) r = ACC_MIN;
      return r[ACC_WIDTH-1:0];
    end
  endfunction

  assign dp_stat.out_free = !out_valid || !out_stall;

  // Operand select for the shared multiplier.
  always_comb begin
    mul_en   = 1'b1;
    mul_coef = coef_b0;
    mul_data = x_reg;
    case (dp_cmd.op)
      biq_pkg::OP_LOAD: begin
        mul_coef = coef_b0;
        mul_data = sample_in;
      end
      biq_pkg::OP_Y: begin
        mul_coef = coef_b1;
        mul_data = x_reg;
      end
      biq_pkg::OP_A1: begin
        mul_coef = coef_a1;
        mul_data = y_reg;
      end
      biq_pkg::OP_B2: begin
        mul_coef = coef_b2;
        mul_data = x_reg;
      end
      biq_pkg::OP_A2: begin
        mul_coef = coef_a2;
        mul_data = y_reg;
      end
      default: mul_en = 1'b0;
    endcase
  end

  // Output rounding and saturation, and saturation of the new delay values.
  always_comb begin
    prod_ext = SUM_W'(prod);
    sum_y    = prod_ext + SUM_W'(delay_first) + ROUND;
    y_shr    = $signed(sum_y[SUM_W-1:FRAC]);
    y_hit    = 1'b0;
    y_sat    = y_shr[SAMPLE_WIDTH-1:0];
    if (y_shr > Y_MAX) begin
      y_hit = 1'b1;
      y_sat = Y_MAX[SAMPLE_WIDTH-1:0];
    end else if (y_shr < Y_MIN) begin
      y_hit = 1'b1;
      y_sat = Y_MIN[SAMPLE_WIDTH-1:0];
    end
    n1_sum = acc;
    n2_sum = acc - prod_ext;
    n1_sat = clamp_acc(n1_sum);
    n2_sat = clamp_acc(n2_sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_b0 <= COEF_ONE;
      coef_b1 <= '0;
      coef_b2 <= '0;
      coef_a1 <= '0;
      coef_a2 <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        biq_pkg::CFG_B0: coef_b0 <= cfg_data;
        biq_pkg::CFG_B1: coef_b1 <= cfg_data;
        biq_pkg::CFG_B2: coef_b2 <= cfg_data;
        biq_pkg::CFG_A1: coef_a1 <= cfg_data;
        biq_pkg::CFG_A2: coef_a2 <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mul_en) prod <= PROD_W'(mul_coef) * PROD_W'(mul_data);
    case (dp_cmd.op)
      biq_pkg::OP_LOAD: x_reg <= sample_in;
      biq_pkg::OP_Y: begin
        y_reg    <= y_sat;
        clip_reg <= y_hit;
      end
      biq_pkg::OP_A1: acc <= prod_ext + SUM_W'(delay_second);
      biq_pkg::OP_B2: acc <= acc - prod_ext;
      biq_pkg::OP_A2: acc <= prod_ext;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_first  <= '0;
      delay_second <= '0;
    end else begin
      case (dp_cmd.op)
        biq_pkg::OP_CLEAR: begin
          delay_first  <= '0;
          delay_second <= '0;
        end
        biq_pkg::OP_A2:  delay_first  <= n1_sat;
        biq_pkg::OP_FIN: delay_second <= n2_sat;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (dp_cmd.op == biq_pkg::OP_FIN) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.op == biq_pkg::OP_FIN) begin
      sample_out <= y_reg;
      clipped    <= clip_reg;
    end
  end

endmodule

`default_nettype wire

>>> rtl/biquad_iir_filter.sv
// Biquad IIR section, direct form II transposed; uses biq_pkg, biq_ctrl, biq_datapath.
// One sample request is processed at a time: the single shared multiplier forms
//   b0*x, b1*x, a1*y, b2*x and a2*y in turn, and no new request is taken until
//   the result is registered; a clear is taken while idle and gives no result.
// Reset: synchronous, active high; zeroes both delays, sets b0 to 1.0 and the
//   other coefficients to 0, and drops any pending result.
`default_nettype none

module biquad_iir_filter #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int COEF_WIDTH   = 18,
  parameter int ACC_WIDTH    = 40
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // Configuration writes; only while the filter is idle.
  input  wire logic                          cfg_we,
  input  wire logic [biq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [COEF_WIDTH-1:0]         cfg_data,
  // Sample request channel.
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          cmd,
  input  wire logic signed [SAMPLE_WIDTH-1:0] sample_in,
  // Result channel.
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]     sample_out,
  output logic                               clipped
);

  biq_pkg::dp_cmd_t  dp_cmd;
  biq_pkg::dp_stat_t dp_stat;

  // Sequencer: take a request when idle, then walk through the products.
  // It holds in the final step while an earlier result still waits downstream.
  biq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .cmd      (cmd),
    .in_stall (in_stall),
    .dp_cmd   (dp_cmd),
    .dp_stat  (dp_stat)
  );

  // Datapath: the first product b0*x is formed on the accept edge itself,
  // the rounded and saturated y is fed back into the a1 and a2 products.
  biq_datapath #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COEF_WIDTH   (COEF_WIDTH),
    .ACC_WIDTH    (ACC_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .sample_in  (sample_in),
    .dp_cmd     (dp_cmd),
    .dp_stat    (dp_stat),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sample_out (sample_out),
    .clipped    (clipped)
  );

endmodule

`default_nettype wire

>>> rtl/biq_checker.sv
// Port-level checks of the biquad filter, bound to the top level.
// Depends on assert_macros.svh and biquad_iir_filter.
`default_nettype none
`include "assert_macros.svh"

module biq_checker #(
  parameter int SAMPLE_WIDTH = 16
) (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           in_valid,
  input wire logic                           in_stall,
  input wire logic                           cmd,
  input wire logic                           out_valid,
  input wire logic                           out_stall,
  input wire logic signed [SAMPLE_WIDTH-1:0] sample_out,
  input wire logic                           clipped
);

  localparam logic signed [SAMPLE_WIDTH-1:0] S_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] S_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)
  `ASSERT_NEXT(a_out_stable, clk, rst, out_valid && out_stall, $stable(sample_out) && $stable(clipped))
  `ASSERT_NEXT(a_busy_after_sample, clk, rst, in_valid && !in_stall && !cmd, in_stall)
  `ASSERT_NEXT(a_clear_no_result, clk, rst, in_valid && !in_stall && cmd && !out_valid, !out_valid && !in_stall)
  `ASSERT_IMPL(a_clip_at_rail, clk, rst, out_valid && clipped, (sample_out == S_MAX) || (sample_out == S_MIN))

endmodule

bind biquad_iir_filter biq_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_chk (.*);

`default_nettype wire

>>> test/biquad_iir_filter_test.sv
// Self-checking testbench for the biquad IIR section (direct form II transposed).
// Predicts each filtered sample in a small scoreboard class; depends on biq_pkg
// and biquad_iir_filter only.

module biquad_iir_filter_test;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 18;
  localparam int ACC_W    = 40;
  localparam int FRAC     = COEF_W - 4;

  localparam logic signed [COEF_W-1:0] COEF_MAX  = 18'sd131071;
  localparam logic signed [COEF_W-1:0] COEF_MIN  = -18'sd131072;
  localparam logic signed [COEF_W-1:0] COEF_ONE  = 18'sd16384;
  localparam logic signed [COEF_W-1:0] COEF_HALF = 18'sd8192;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sd32767;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -16'sd32768;

  // Time the block is given after the last result before it counts as idle.
  localparam int SETTLE_CYCLES = 10;
  localparam int CYCLE_LIMIT   = 200000;

  // ---------------------------------------------------------------------------
  // Scoreboard: own copy of the coefficients and the two delay accumulators,
  // and the queue of filtered samples still to come out of the block.
  // ---------------------------------------------------------------------------
  class biquad_scoreboard;
    typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       clip;
    } filtered_t;

    localparam longint ACC_HI = (longint'(1) <<< (ACC_W - 1)) - 1;
    localparam longint ACC_LO = -ACC_HI - 1;
    localparam longint Y_HI   = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
    localparam longint Y_LO   = -Y_HI - 1;

    longint b0, b1, b2, a1, a2;
    longint delay_first, delay_second;
    filtered_t expected_outputs[$];
    int errors;

    function void reset_state();
      b0 = longint'(COEF_ONE);
      b1 = 0;
      b2 = 0;
      a1 = 0;
      a2 = 0;
      delay_first = 0;
      delay_second = 0;
      expected_outputs.delete();
      errors = 0;
    endfunction

    function void write_coef(logic [biq_pkg::CFG_IDX_W-1:0] index, logic [COEF_W-1:0] data);
      longint value;
      value = longint'($signed(data));
      case (index)
        biq_pkg::CFG_B0: b0 = value;
        biq_pkg::CFG_B1: b1 = value;
        biq_pkg::CFG_B2: b2 = value;
        biq_pkg::CFG_A1: a1 = value;
        biq_pkg::CFG_A2: a2 = value;
        default: ;  // unused index: drop the write
      endcase
    endfunction

    function longint clamp_acc(longint value);
      if (value > ACC_HI) return ACC_HI;
      if (value < ACC_LO) return ACC_LO;
      return value;
    endfunction

    // Advance the filter by one accepted request.
    function void note_request(logic op, logic signed [SAMPLE_W-1:0] sample);
      longint x, acc, y, next_first, next_second;
      filtered_t result;
      if (op == biq_pkg::CMD_CLEAR) begin
        delay_first = 0;
        delay_second = 0;
        return;
      end
      x = longint'(sample);
      // Products fit in 34 bits and the delays in 40, so 64-bit sums never wrap.
      acc = b0 * x + delay_first + (longint'(1) <<< (FRAC - 1));
      y = acc >>> FRAC;
      result.clip = 1'b0;
      if (y > Y_HI) begin
        y = Y_HI;
        result.clip = 1'b1;
      end else if (y < Y_LO) begin
        y = Y_LO;
        result.clip = 1'b1;
      end
      // Feed back the saturated output.
      next_first = b1 * x - a1 * y + delay_second;
      next_second = b2 * x - a2 * y;
      delay_first = clamp_acc(next_first);
      delay_second = clamp_acc(next_second);
      result.sample = y[SAMPLE_W-1:0];
      expected_outputs.push_back(result);
    endfunction

    function void check_result(logic signed [SAMPLE_W-1:0] sample, logic clip);
      filtered_t want;
      if (expected_outputs.size() == 0) begin
        $error("unexpected result: sample_out %0d, clipped %0b", sample, clip);
        errors++;
        return;
      end
      want = expected_outputs.pop_front();
      if (sample !== want.sample) begin
        $error("sample_out: expected %0d, got %0d", want.sample, sample);
        errors++;
      end
      if (clip !== want.clip) begin
        $error("clipped: expected %0b, got %0b", want.clip, clip);
        errors++;
      end
    endfunction

    function int pending();
      return expected_outputs.size();
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Block under test; every input starts at a known value.
  // ---------------------------------------------------------------------------
  logic                          clk;
  logic                          rst        = 1'b1;
  logic                          cfg_we     = 1'b0;
  logic [biq_pkg::CFG_IDX_W-1:0] cfg_index  = biq_pkg::CFG_B0;
  logic [COEF_W-1:0]             cfg_data   = '0;
  logic                          in_valid   = 1'b0;
  logic                          in_stall;
  logic                          cmd        = biq_pkg::CMD_FILTER;
  logic signed [SAMPLE_W-1:0]    sample_in  = '0;
  logic                          out_valid;
  logic                          out_stall  = 1'b0;
  logic signed [SAMPLE_W-1:0]    sample_out;
  logic                          clipped;

  biquad_iir_filter dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .sample_in (sample_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sample_out(sample_out),
    .clipped   (clipped)
  );

  biquad_scoreboard filter_track;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: end the run if it hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("biquad_iir_filter test failed");
      $finish;
    end
  end

  // Receiver: check each accepted result, then pick the stall for the next edge.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      filter_track.check_result(sample_out, clipped);
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // ---------------------------------------------------------------------------
  // Driver tasks
  // ---------------------------------------------------------------------------

  // Offer one request, idling first at random; hold the payload while stalled.
  // Valid stays high on return so that back-to-back requests leave no gap.
  task automatic send_request(input logic op, input logic signed [SAMPLE_W-1:0] value);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid  <= 1'b1;
    cmd       <= op;
    sample_in <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    filter_track.note_request(op, value);
  endtask

  // Drop valid, wait for every expected result, then let a clear or a
  // result still in flight finish before anyone touches the registers.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (filter_track.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all five coefficients back to back; optionally also hit the unused
  // indexes with random data, which the block must ignore.
  task automatic load_coefs(input logic [COEF_W-1:0] b0, input logic [COEF_W-1:0] b1,
                            input logic [COEF_W-1:0] b2, input logic [COEF_W-1:0] a1,
                            input logic [COEF_W-1:0] a2, input bit hit_unused);
    logic [COEF_W-1:0]             values[5];
    logic [biq_pkg::CFG_IDX_W-1:0] index;
    logic [COEF_W-1:0]             junk;
    values = '{b0, b1, b2, a1, a2};
    for (int i = 0; i < 5; i++) begin
      index = biq_pkg::CFG_B0 + biq_pkg::CFG_IDX_W'(i);
      cfg_we    <= 1'b1;
      cfg_index <= index;
      cfg_data  <= values[i];
      @(posedge clk);
      filter_track.write_coef(index, values[i]);
    end
    if (hit_unused) begin
      for (int k = 1; biq_pkg::CFG_A2 + k < (1 << biq_pkg::CFG_IDX_W); k++) begin
        index = biq_pkg::CFG_A2 + biq_pkg::CFG_IDX_W'(k);
        junk  = COEF_W'($urandom);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= junk;
        @(posedge clk);
        filter_track.write_coef(index, junk);
      end
    end
    cfg_we <= 1'b0;
  endtask

  // Coefficient by style: full range, a gentle (mostly stable) section, or extremes.
  function automatic logic [COEF_W-1:0] pick_coef(int style, bit feedback);
    case (style)
      0: return COEF_W'($urandom);
      1: begin
        if (feedback) return COEF_W'(int'($urandom_range(16384)) - 8192);
        return COEF_W'(int'($urandom_range(32768)) - 16384);
      end
      default: begin
        case ($urandom_range(4))
          0: return COEF_MAX;
          1: return COEF_MIN;
          2: return COEF_ONE;
          3: return -COEF_ONE;
          default: return '0;
        endcase
      end
    endcase
  endfunction

  // Mostly full-range samples, with the extremes and small values mixed in.
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int roll;
    roll = $urandom_range(99);
    if (roll < 8) return SAMPLE_MAX;
    if (roll < 16) return SAMPLE_MIN;
    if (roll < 30) return SAMPLE_W'(int'($urandom_range(512)) - 256);
    return SAMPLE_W'($urandom);
  endfunction

  // One random stretch: settle, load a fresh setting, stream requests.
  // A pause below zero means no mid-stream pause.
  task automatic run_segment(input int style, input int count, input int pause_at);
    logic op;
    settle();
    load_coefs(pick_coef(style, 0), pick_coef(style, 0), pick_coef(style, 0),
               pick_coef(style, 1), pick_coef(style, 1), style == 0);
    for (int i = 0; i < count; i++) begin
      if (i == pause_at) settle();
      op = ($urandom_range(99) < 4) ? biq_pkg::CMD_CLEAR : biq_pkg::CMD_FILTER;
      send_request(op, pick_sample());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    filter_track = new();
    filter_track.reset_state();

    // Hold reset, then release it.
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: unity gain passes the sample extremes and small values straight through.
    send_request(biq_pkg::CMD_FILTER, SAMPLE_MAX);
    send_request(biq_pkg::CMD_FILTER, SAMPLE_MIN);
    send_request(biq_pkg::CMD_FILTER, 16'sd0);
    send_request(biq_pkg::CMD_FILTER, 16'sd1);
    send_request(biq_pkg::CMD_FILTER, -16'sd1);
    // Clear with a nonzero sample: sample is ignored, no result.
    send_request(biq_pkg::CMD_CLEAR, SAMPLE_MIN);

    // Half gain: exact ties must round toward plus infinity.
    settle();
    load_coefs(COEF_HALF, '0, '0, '0, '0, 1'b0);
    send_request(biq_pkg::CMD_FILTER, 16'sd1);
    send_request(biq_pkg::CMD_FILTER, -16'sd1);
    send_request(biq_pkg::CMD_FILTER, 16'sd3);
    send_request(biq_pkg::CMD_FILTER, -16'sd3);

    // Coefficient extremes: drive the output into saturation, feed the clipped
    // value back, and write the unused indexes along the way.
    settle();
    load_coefs(COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, 1'b1);
    send_request(biq_pkg::CMD_FILTER, SAMPLE_MAX);
    send_request(biq_pkg::CMD_FILTER, SAMPLE_MIN);
    send_request(biq_pkg::CMD_FILTER, 16'sd100);
    send_request(biq_pkg::CMD_FILTER, SAMPLE_MIN);
    send_request(biq_pkg::CMD_CLEAR, SAMPLE_MAX);
    send_request(biq_pkg::CMD_FILTER, SAMPLE_MIN);
    send_request(biq_pkg::CMD_FILTER, SAMPLE_MAX);

    settle();
    load_coefs(COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, 1'b0);
    send_request(biq_pkg::CMD_FILTER, SAMPLE_MAX);
    send_request(biq_pkg::CMD_FILTER, SAMPLE_MAX);
    send_request(biq_pkg::CMD_FILTER, SAMPLE_MIN);

    // Random: sender idles lightly, receiver stalls heavily.
    send_idle_pct = 18;
    recv_idle_pct = 56;
    run_segment(0, 100, 50);
    run_segment(1, 100, -1);

    // Swap the idling roles.
    send_idle_pct = 56;
    recv_idle_pct = 18;
    run_segment(2, 100, -1);
    run_segment(1, 100, -1);

    // Full speed on both sides.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_segment(0, 100, -1);
    run_segment(1, 100, -1);

    // Drain everything still in flight and report.
    settle();
    if (filter_track.errors == 0)
      $display("biquad_iir_filter test passed");
    else
      $display("biquad_iir_filter test failed");
    $finish;
  end

endmodule
